### src/prs_pkg.sv
package prs_pkg;

	localparam int unsigned RATIO_CEIL = 128;

	localparam int unsigned FREQ_W  = 32;
	localparam int unsigned RATIO_W = $clog2(RATIO_CEIL + 1);
	localparam int unsigned PLL_W   = FREQ_W + RATIO_W;
	localparam int unsigned OUT_W   = 7;
	localparam int unsigned CFG_W   = 1;

	localparam logic [FREQ_W-1:0] WIN_LOW_RST  = 32'd700000000;
	localparam logic [FREQ_W-1:0] WIN_HIGH_RST = 32'd1300000000;

	// register indexes on the configuration channel
	localparam logic [CFG_W-1:0] CFG_WIN_LOW  = 1'b0;
	localparam logic [CFG_W-1:0] CFG_WIN_HIGH = 1'b1;

	localparam logic [RATIO_W-1:0] PASS1_FIRST = RATIO_W'(1);
	localparam logic [RATIO_W-1:0] PASS1_LAST  = RATIO_W'(3);
	localparam logic [RATIO_W-1:0] PASS2_FIRST = RATIO_W'(4);
	localparam logic [RATIO_W:0]   RATIO_LIMIT = (RATIO_W + 1)'(RATIO_CEIL);

endpackage

### src/pll_ratio_search_core.sv
// search: an inverted window goes straight to the result without examining any ratio;
// otherwise the first pass examines ratios 1..3 and, if none matches, the second pass
// examines even ratios from 4 up to RATIO_CEIL-2; either pass stops once above the window
// throughput: one item at a time, next beat taken the cycle after the result loads;
// one candidate per cycle through the shared distance subtract and compare
// reset: arst_n clears control state and loads the window registers with 700M/1300M
module pll_ratio_search_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prs_pkg::FREQ_W-1:0]    target_freq,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [prs_pkg::OUT_W-1:0]     best_ratio,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [prs_pkg::CFG_W-1:0]     cfg_index,
	input  logic [prs_pkg::FREQ_W-1:0]    cfg_data
);
	import prs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PASS1 = 4'b0010,
		ST_PASS2 = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [FREQ_W-1:0]    win_low_q;
	logic [FREQ_W-1:0]    win_high_q;
	logic [FREQ_W-1:0]    target_q;
	logic [FREQ_W-1:0]    mid_q;
	logic [PLL_W-1:0]     pll_q;
	logic [PLL_W-1:0]     best_dist_q;
	logic [RATIO_W-1:0]   ratio_q;
	logic [RATIO_W-1:0]   best_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [OUT_W-1:0]     best_ratio_q;

	logic                 in_beat;
	logic                 res_load;
	logic                 over;
	logic                 in_win;
	logic [PLL_W-1:0]     mid_ext;
	logic [PLL_W-1:0]     cand_dist;
	logic                 better;
	logic [RATIO_W-1:0]   best_now;
	logic [RATIO_W-1:0]   ratio_nxt;
	logic                 pass2_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_beat   = in_valid && in_ready;
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign best_ratio = best_ratio_q;

	// shared candidate unit
	always_comb begin
		mid_ext  = PLL_W'(mid_q);
		over     = pll_q > PLL_W'(win_high_q);
		in_win   = (pll_q > PLL_W'(win_low_q)) && (pll_q < PLL_W'(win_high_q));
		cand_dist = (pll_q < mid_ext) ? (mid_ext - pll_q) : (pll_q - mid_ext);
		better   = !over && in_win && (cand_dist < best_dist_q);
		best_now = better ? ratio_q : best_q;
		ratio_nxt = ratio_q + RATIO_W'(2);
		// no room for another even ratio up to RATIO_CEIL-2
		pass2_end = ({1'b0, ratio_nxt} + (RATIO_W + 1)'(2)) > RATIO_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low_q  <= WIN_LOW_RST;
			win_high_q <= WIN_HIGH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIN_LOW:  win_low_q  <= cfg_data;
				CFG_WIN_HIGH: win_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (win_low_q > win_high_q)
							state_q <= ST_DONE;
						else
							state_q <= ST_PASS1;
					end
				end
				ST_PASS1: begin
					if (over || ratio_q == PASS1_LAST) begin
						if (best_now == '0)
							state_q <= ST_PASS2;
						else
							state_q <= ST_DONE;
					end
				end
				ST_PASS2: begin
					if (over || pass2_end)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					target_q    <= target_freq;
					mid_q       <= win_low_q + ((win_high_q - win_low_q) >> 1);
					best_dist_q <= PLL_W'(win_high_q - win_low_q);
					best_q      <= '0;
					ratio_q     <= PASS1_FIRST;
					pll_q       <= PLL_W'(target_freq);
				end
			end
			ST_PASS1: begin
				if (better) begin
					best_dist_q <= cand_dist;
					best_q      <= ratio_q;
				end
				if (over || ratio_q == PASS1_LAST) begin
					ratio_q <= PASS2_FIRST;
					pll_q   <= PLL_W'(target_q) << 2;
				end else begin
					ratio_q <= ratio_q + RATIO_W'(1);
					pll_q   <= pll_q + PLL_W'(target_q);
				end
			end
			ST_PASS2: begin
				if (better) begin
					best_dist_q <= cand_dist;
					best_q      <= ratio_q;
				end
				ratio_q <= ratio_nxt;
				pll_q   <= pll_q + (PLL_W'(target_q) << 1);
			end
			ST_DONE: begin
				if (res_load) begin
					found_q      <= (best_q != '0);
					best_ratio_q <= best_q[OUT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_ratio == '0)
		else $error("result without a match carries a non-zero ratio");

	a_pass1_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS1 |-> ratio_q >= PASS1_FIRST && ratio_q <= PASS1_LAST)
		else $error("first pass ratio out of range");

	a_pass2_even: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS2 |-> !ratio_q[0] && ratio_q >= PASS2_FIRST)
		else $error("second pass ratio odd or too small");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("block still ready after taking a beat");

	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS2 || state_q == ST_PASS1 |->
			best_dist_q <= PLL_W'(win_high_q - win_low_q))
		else $error("best distance above the window span");

endmodule
